// File: rtl/core/cca_pkg.sv
// Shared types, codes and constants for the circuit channel allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Has no dependencies of its own.
package cca_pkg;

	// Default sizing of the circuit group.
	localparam int CIRCUITS_DEF  = 32;
	localparam int LOCK_BITS_DEF = 8;

	// Fixed field widths of the request, response and configuration channels.
	localparam int ACTION_W   = 3;
	localparam int CODE_W     = 16;
	localparam int MASK_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int ORDER_W    = 3;
	localparam int PARITY_W   = 2;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	// Random start generator: 16-bit Galois LFSR.
	localparam int          LFSR_W    = 16;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	// The start-point remainder is taken over a dividend of the LFSR width.
	localparam int DIV_W   = LFSR_W;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// Request actions.
	localparam logic [ACTION_W-1:0] ACT_RESERVE = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_ADD     = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_REMOVE  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_SETLOCK = 3'd4;

	// Response status codes.
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_CODE  = 2'd3;

	// Allocation orders; any code above ORD_HIGH means a random start.
	localparam logic [ORDER_W-1:0] ORD_INC  = 3'd0;
	localparam logic [ORDER_W-1:0] ORD_DEC  = 3'd1;
	localparam logic [ORDER_W-1:0] ORD_LOW  = 3'd2;
	localparam logic [ORDER_W-1:0] ORD_HIGH = 3'd3;

	// Parity limits; the fourth code behaves as no limit.
	localparam logic [PARITY_W-1:0] PAR_ANY     = 2'd0;
	localparam logic [PARITY_W-1:0] PAR_EVEN    = 2'd1;
	localparam logic [PARITY_W-1:0] PAR_ODD     = 2'd2;
	localparam logic [PARITY_W-1:0] PAR_ANY_ALT = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] CFG_ORDER    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_PARITY   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_FALLBACK = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_BASE     = 2'd3;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_START,
		S_SCAN,
		S_RETRY,
		S_WALK,
		S_FINISH
	} ctrl_state_t;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_APPLY,
		OP_EMPTY,
		OP_PASS_INIT,
		OP_DIV_STEP,
		OP_START,
		OP_SCAN,
		OP_WALK
	} dp_op_t;

	// Command bundle from the controller to the datapath.
	typedef struct packed {
		logic   load_req;
		dp_op_t op;
		logic   fallback;
		logic   out_load;
	} dp_cmd_t;

	// Status bundle from the datapath to the controller.
	typedef struct packed {
		logic is_reserve;
		logic top_zero;
		logic use_div;
		logic need_walk;
		logic div_last;
		logic hit;
		logic scan_end;
		logic fallback_ok;
		logic walk_done;
	} dp_sts_t;

	// True when the low bit of a code satisfies the parity limit.
	function automatic logic parity_ok(input logic lsb, input logic [PARITY_W-1:0] par);
		logic ok;
		begin
			ok = 1'b1;
			if (par == PAR_EVEN) begin
				ok = !lsb;
			end else if (par == PAR_ODD) begin
				ok = lsb;
			end
			return ok;
		end
	endfunction

endpackage

// File: rtl/core/cca_if.sv
// Valid/ready channel interfaces for requests, responses and configuration writes.
// Depends on cca_pkg for the field widths.
interface cca_req_if;
	logic                          valid;
	logic                          ready;
	logic [cca_pkg::ACTION_W-1:0]  action;
	logic [cca_pkg::CODE_W-1:0]    circuit_code;
	logic [cca_pkg::MASK_W-1:0]    lock_check_mask;
	logic [cca_pkg::MASK_W-1:0]    lock_value;
	logic                          swap_parity;

	modport source (output valid, action, circuit_code, lock_check_mask, lock_value,
		swap_parity, input ready);
	modport sink (input valid, action, circuit_code, lock_check_mask, lock_value,
		swap_parity, output ready);
endinterface

interface cca_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cca_pkg::CODE_W-1:0]    granted_code;
	logic [cca_pkg::STATUS_W-1:0]  result_status;

	modport source (output valid, granted_code, result_status, input ready);
	modport sink (input valid, granted_code, result_status, output ready);
endinterface

interface cca_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [cca_pkg::CFG_ADDR_W-1:0]  addr;
	logic [cca_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// File: rtl/core/cca_datapath.sv
// Datapath of the circuit allocator: circuit marks, configuration registers,
// start-point remainder unit, scan pointer and result registers. Uses cca_pkg.
module cca_datapath #(
	parameter int CIRCUITS  = cca_pkg::CIRCUITS_DEF,
	parameter int LOCK_BITS = cca_pkg::LOCK_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cca_pkg::dp_cmd_t                cmd,
	output cca_pkg::dp_sts_t                sts,
	input  logic [cca_pkg::ACTION_W-1:0]    action,
	input  logic [cca_pkg::CODE_W-1:0]      circuit_code,
	input  logic [cca_pkg::MASK_W-1:0]      lock_check_mask,
	input  logic [cca_pkg::MASK_W-1:0]      lock_value,
	input  logic                            swap_parity,
	input  logic                            cfg_we,
	input  logic [cca_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [cca_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [cca_pkg::CODE_W-1:0]      granted_code,
	output logic [cca_pkg::STATUS_W-1:0]    result_status
);

	localparam int IW = $clog2(CIRCUITS);
	localparam int CW = $clog2(CIRCUITS + 1);

	// Configuration registers.
	logic [cca_pkg::ORDER_W-1:0]  order_q;
	logic [cca_pkg::PARITY_W-1:0] limit_q;
	logic                         fallback_q;
	logic [cca_pkg::CODE_W-1:0]   base_q;

	// Circuit state.
	logic [CIRCUITS-1:0]  present_q;
	logic [CIRCUITS-1:0]  busy_q;
	logic [LOCK_BITS-1:0] lock_q [CIRCUITS];
	logic [IW-1:0]        last_q;
	logic [CW-1:0]        top_q;
	logic [cca_pkg::LFSR_W-1:0] lfsr_q;

	// Captured request.
	logic [cca_pkg::ACTION_W-1:0] action_q;
	logic [IW-1:0]                local_q;
	logic                         code_ok_q;
	logic [LOCK_BITS-1:0]         mask_q;
	logic [LOCK_BITS-1:0]         value_q;
	logic                         swap_q;

	// Scan and remainder working registers.
	logic [cca_pkg::PARITY_W-1:0]  par_q;
	logic [CW-1:0]                 n_q;
	logic [CW-1:0]                 start_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 rem_q;
	logic [cca_pkg::DIV_W-1:0]     div_q;
	logic [cca_pkg::DIV_CNT_W-1:0] dcnt_q;

	// Result and output registers.
	logic [cca_pkg::CODE_W-1:0]   res_code_q;
	logic [cca_pkg::STATUS_W-1:0] res_status_q;
	logic [cca_pkg::CODE_W-1:0]   out_code_q;
	logic [cca_pkg::STATUS_W-1:0] out_status_q;

	logic [cca_pkg::CODE_W:0]     diff;
	logic                         code_ok;
	logic [IW-1:0]                rd_idx;
	logic [CW-1:0]                n_m1;
	logic                         rd_present;
	logic                         rd_busy;
	logic [LOCK_BITS-1:0]         rd_lock;
	logic [cca_pkg::PARITY_W-1:0] par_first;
	logic [cca_pkg::PARITY_W-1:0] par_next;
	logic [cca_pkg::LFSR_W-1:0]   lfsr_nxt;
	logic [CW-1:0]                top_m1;
	logic [CW:0]                  delta;
	logic [CW:0]                  sum;
	logic [CW:0]                  inc1;
	logic [CW:0]                  wrap1;
	logic [CW-1:0]                nxt;
	logic                         eligible;
	logic                         scan_end;
	logic [CW-1:0]                s0;
	logic [CW-1:0]                r1;
	logic [CW-1:0]                fixed;
	logic [CW:0]                  half;
	logic [CW-1:0]                cnt_init;
	logic [CW:0]                  trial;
	logic [CW:0]                  rem_nxt;
	logic                         apply_ok;
	logic                         use_div;

	// External code to local code, with range check.
	assign diff    = {1'b0, circuit_code} - {1'b0, base_q};
	assign code_ok = !diff[cca_pkg::CODE_W]
		&& (diff[cca_pkg::CODE_W-1:0] < cca_pkg::CODE_W'(CIRCUITS));

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q    <= cca_pkg::ORD_INC;
			limit_q    <= cca_pkg::PAR_ANY;
			fallback_q <= 1'b0;
			base_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				cca_pkg::CFG_ORDER:    order_q    <= cfg_data[cca_pkg::ORDER_W-1:0];
				cca_pkg::CFG_PARITY:   limit_q    <= cfg_data[cca_pkg::PARITY_W-1:0];
				cca_pkg::CFG_FALLBACK: fallback_q <= cfg_data[0];
				cca_pkg::CFG_BASE:     base_q     <= cfg_data[cca_pkg::CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			action_q  <= action;
			local_q   <= diff[IW-1:0];
			code_ok_q <= code_ok;
			mask_q    <= LOCK_BITS'(lock_check_mask);
			value_q   <= LOCK_BITS'(lock_value);
			swap_q    <= swap_parity;
		end
	end

	// Single read port into the circuit marks.
	assign n_m1 = n_q - CW'(1);
	always_comb begin
		case (cmd.op)
			cca_pkg::OP_APPLY: rd_idx = local_q;
			cca_pkg::OP_WALK:  rd_idx = n_m1[IW-1:0];
			default:           rd_idx = n_q[IW-1:0];
		endcase
	end
	assign rd_present = present_q[rd_idx];
	assign rd_busy    = busy_q[rd_idx];
	assign rd_lock    = lock_q[rd_idx];

	// Parity restriction for the first pass and for the fallback pass.
	always_comb begin
		par_first = (limit_q == cca_pkg::PAR_ANY_ALT) ? cca_pkg::PAR_ANY : limit_q;
		if (swap_q && (par_first != cca_pkg::PAR_ANY)) begin
			par_first = cca_pkg::PARITY_W'(3) - par_first;
		end
		par_next = cmd.fallback ? (cca_pkg::PARITY_W'(3) - par_q) : par_first;
	end

	assign lfsr_nxt = (lfsr_q >> 1) ^ (lfsr_q[0] ? cca_pkg::LFSR_TAPS : '0);
	assign use_div  = (order_q == cca_pkg::ORD_INC) || order_q[cca_pkg::ORDER_W-1];
	assign top_m1   = top_q - CW'(1);

	// Next candidate of the scan.
	always_comb begin
		delta = (par_q != cca_pkg::PAR_ANY) ? (CW+1)'(2) : (CW+1)'(1);
		sum   = {1'b0, n_q} + delta;
		inc1  = {1'b0, n_q} + (CW+1)'(1);
		wrap1 = (inc1 >= {1'b0, top_q}) ? (inc1 - {1'b0, top_q}) : inc1;
		case (order_q)
			cca_pkg::ORD_INC, cca_pkg::ORD_LOW: begin
				if (sum >= {1'b0, top_q}) begin
					nxt = (par_q == cca_pkg::PAR_ODD) ? CW'(1) : '0;
				end else begin
					nxt = sum[CW-1:0];
				end
			end
			cca_pkg::ORD_DEC, cca_pkg::ORD_HIGH: begin
				if ({1'b0, n_q} >= delta) begin
					nxt = n_q - delta[CW-1:0];
				end else begin
					nxt = top_m1;
					if (!cca_pkg::parity_ok(top_m1[0], par_q) && (top_m1 != '0)) begin
						nxt = top_m1 - CW'(1);
					end
				end
			end
			default: begin
				nxt = (wrap1 >= {1'b0, top_q}) ? '0 : wrap1[CW-1:0];
			end
		endcase
	end

	// Candidate test and end-of-pass detection.
	assign eligible = (n_q < top_q) && rd_present && !rd_busy
		&& ((rd_lock & mask_q) == '0) && cca_pkg::parity_ok(n_q[0], par_q);
	assign scan_end = !eligible && ((cnt_q == CW'(1)) || (nxt == start_q));

	// Start point of a pass, parity fixed, and its candidate budget.
	always_comb begin
		r1 = rem_q + CW'(1);
		case (order_q)
			cca_pkg::ORD_INC:  s0 = rem_q;
			cca_pkg::ORD_DEC:  s0 = ((last_q != '0) ? CW'(last_q) : top_q) - CW'(1);
			cca_pkg::ORD_LOW:  s0 = '0;
			cca_pkg::ORD_HIGH: s0 = top_m1;
			default: begin
				s0 = rem_q;
				if ((top_q > CW'(1)) && (rem_q == CW'(last_q))) begin
					s0 = (r1 == top_q) ? '0 : r1;
				end
			end
		endcase
		fixed = s0;
		if (par_q == cca_pkg::PAR_EVEN) begin
			fixed[0] = 1'b0;
		end else if (par_q == cca_pkg::PAR_ODD) begin
			fixed[0] = 1'b1;
		end
		half     = ({1'b0, top_q} + (CW+1)'(1)) >> 1;
		cnt_init = (par_q != cca_pkg::PAR_ANY) ? half[CW-1:0] : top_q;
	end

	// One restoring step of the remainder unit.
	always_comb begin
		trial   = {rem_q, div_q[cca_pkg::DIV_W-1]};
		rem_nxt = (trial >= {1'b0, top_q}) ? (trial - {1'b0, top_q}) : trial;
	end

	// Whether a release, add, remove or lock change applies.
	always_comb begin
		case (action_q)
			cca_pkg::ACT_RELEASE, cca_pkg::ACT_REMOVE, cca_pkg::ACT_SETLOCK:
				apply_ok = code_ok_q && rd_present;
			cca_pkg::ACT_ADD:
				apply_ok = code_ok_q && !rd_present;
			default:
				apply_ok = 1'b0;
		endcase
	end

	// Status toward the controller.
	always_comb begin
		sts.is_reserve  = (action_q == cca_pkg::ACT_RESERVE);
		sts.top_zero    = (top_q == '0);
		sts.use_div     = use_div;
		sts.need_walk   = (action_q == cca_pkg::ACT_REMOVE) && apply_ok
			&& ((CW'(local_q) + CW'(1)) == top_q);
		sts.div_last    = (dcnt_q == '0);
		sts.hit         = eligible;
		sts.scan_end    = scan_end;
		sts.fallback_ok = fallback_q && (par_q != cca_pkg::PAR_ANY);
		sts.walk_done   = (n_q == '0) || rd_present;
	end

	// Circuit marks, top code, last grant and the random generator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			busy_q    <= '0;
			last_q    <= '0;
			top_q     <= '0;
			lfsr_q    <= cca_pkg::LFSR_SEED;
		end else begin
			case (cmd.op)
				cca_pkg::OP_APPLY: begin
					if (apply_ok) begin
						case (action_q)
							cca_pkg::ACT_RELEASE: busy_q[local_q] <= 1'b0;
							cca_pkg::ACT_ADD: begin
								present_q[local_q] <= 1'b1;
								busy_q[local_q]    <= 1'b0;
								if (top_q <= CW'(local_q)) begin
									top_q <= CW'(local_q) + CW'(1);
								end
							end
							cca_pkg::ACT_REMOVE: begin
								present_q[local_q] <= 1'b0;
								busy_q[local_q]    <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				cca_pkg::OP_PASS_INIT: begin
					if (order_q[cca_pkg::ORDER_W-1]) begin
						lfsr_q <= lfsr_nxt;
					end
				end
				cca_pkg::OP_SCAN: begin
					if (eligible) begin
						busy_q[n_q[IW-1:0]] <= 1'b1;
						last_q              <= n_q[IW-1:0];
					end
				end
				cca_pkg::OP_WALK: begin
					if (n_q == '0) begin
						top_q <= '0;
					end else if (rd_present) begin
						top_q <= n_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Lock flags; a circuit's flags are cleared whenever it is added or removed.
	always_ff @(posedge clk) begin
		if ((cmd.op == cca_pkg::OP_APPLY) && apply_ok) begin
			case (action_q)
				cca_pkg::ACT_ADD, cca_pkg::ACT_REMOVE: lock_q[local_q] <= '0;
				cca_pkg::ACT_SETLOCK:                  lock_q[local_q] <= value_q;
				default: ;
			endcase
		end
	end

	// Working registers of the scan, the remainder unit and the result.
	always_ff @(posedge clk) begin
		case (cmd.op)
			cca_pkg::OP_APPLY: begin
				res_code_q   <= '0;
				res_status_q <= apply_ok ? cca_pkg::ST_DONE : cca_pkg::ST_BAD_CODE;
				n_q          <= CW'(local_q);
			end
			cca_pkg::OP_EMPTY: begin
				res_code_q   <= '0;
				res_status_q <= cca_pkg::ST_EMPTY;
			end
			cca_pkg::OP_PASS_INIT: begin
				par_q  <= par_next;
				rem_q  <= '0;
				dcnt_q <= cca_pkg::DIV_CNT_W'(cca_pkg::DIV_W - 1);
				if (order_q[cca_pkg::ORDER_W-1]) begin
					div_q <= lfsr_nxt;
				end else begin
					div_q <= cca_pkg::DIV_W'(last_q) + cca_pkg::DIV_W'(1);
				end
			end
			cca_pkg::OP_DIV_STEP: begin
				rem_q  <= rem_nxt[CW-1:0];
				div_q  <= div_q << 1;
				dcnt_q <= dcnt_q - cca_pkg::DIV_CNT_W'(1);
			end
			cca_pkg::OP_START: begin
				n_q     <= fixed;
				start_q <= fixed;
				cnt_q   <= cnt_init;
			end
			cca_pkg::OP_SCAN: begin
				if (eligible) begin
					res_code_q   <= cca_pkg::CODE_W'(n_q) + base_q;
					res_status_q <= cca_pkg::ST_DONE;
				end else if (scan_end) begin
					res_code_q   <= '0;
					res_status_q <= cca_pkg::ST_NONE_FREE;
				end else begin
					n_q   <= nxt;
					cnt_q <= cnt_q - CW'(1);
				end
			end
			cca_pkg::OP_WALK: begin
				if ((n_q != '0) && !rd_present) begin
					n_q <= n_m1;
				end
			end
			default: ;
		endcase
	end

	// Output register; the response payload holds while it waits.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_code_q   <= res_code_q;
			out_status_q <= res_status_q;
		end
	end

	assign granted_code  = out_code_q;
	assign result_status = out_status_q;

endmodule

// File: rtl/core/cca_ctrl.sv
// Controller of the circuit allocator: sequences decode, remainder, scan,
// fallback and top-code recovery, and owns the channel handshakes. Uses cca_pkg.
module cca_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  cca_pkg::dp_sts_t  sts,
	output cca_pkg::dp_cmd_t  cmd
);

	cca_pkg::ctrl_state_t state_q;
	cca_pkg::ctrl_state_t state_d;
	logic                 pass2_q;
	logic                 out_valid_q;
	logic                 retry;
	logic                 can_load;

	// A failed first pass may retry once with the opposite parity.
	assign retry    = sts.scan_end && !sts.hit && sts.fallback_ok && !pass2_q;
	assign can_load = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cca_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = cca_pkg::S_DECODE;
				end
			end
			cca_pkg::S_DECODE: begin
				if (sts.is_reserve) begin
					if (sts.top_zero) begin
						state_d = cca_pkg::S_FINISH;
					end else begin
						state_d = sts.use_div ? cca_pkg::S_DIV : cca_pkg::S_START;
					end
				end else begin
					state_d = sts.need_walk ? cca_pkg::S_WALK : cca_pkg::S_FINISH;
				end
			end
			cca_pkg::S_DIV: begin
				if (sts.div_last) begin
					state_d = cca_pkg::S_START;
				end
			end
			cca_pkg::S_START: state_d = cca_pkg::S_SCAN;
			cca_pkg::S_SCAN: begin
				if (sts.hit) begin
					state_d = cca_pkg::S_FINISH;
				end else if (sts.scan_end) begin
					state_d = retry ? cca_pkg::S_RETRY : cca_pkg::S_FINISH;
				end
			end
			cca_pkg::S_RETRY: state_d = sts.use_div ? cca_pkg::S_DIV : cca_pkg::S_START;
			cca_pkg::S_WALK: begin
				if (sts.walk_done) begin
					state_d = cca_pkg::S_FINISH;
				end
			end
			cca_pkg::S_FINISH: begin
				if (can_load) begin
					state_d = cca_pkg::S_IDLE;
				end
			end
			default: state_d = cca_pkg::S_IDLE;
		endcase
	end

	// Commands and handshake outputs.
	always_comb begin
		cmd.load_req = 1'b0;
		cmd.op       = cca_pkg::OP_NONE;
		cmd.fallback = 1'b0;
		cmd.out_load = 1'b0;
		in_ready     = 1'b0;
		case (state_q)
			cca_pkg::S_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
			end
			cca_pkg::S_DECODE: begin
				if (sts.is_reserve) begin
					cmd.op = sts.top_zero ? cca_pkg::OP_EMPTY : cca_pkg::OP_PASS_INIT;
				end else begin
					cmd.op = cca_pkg::OP_APPLY;
				end
			end
			cca_pkg::S_DIV:   cmd.op = cca_pkg::OP_DIV_STEP;
			cca_pkg::S_START: cmd.op = cca_pkg::OP_START;
			cca_pkg::S_SCAN:  cmd.op = cca_pkg::OP_SCAN;
			cca_pkg::S_RETRY: begin
				cmd.op       = cca_pkg::OP_PASS_INIT;
				cmd.fallback = 1'b1;
			end
			cca_pkg::S_WALK:   cmd.op = cca_pkg::OP_WALK;
			cca_pkg::S_FINISH: cmd.out_load = can_load;
			default: ;
		endcase
	end

	// State, pass tracking and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cca_pkg::S_IDLE;
			pass2_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == cca_pkg::S_DECODE) begin
				pass2_q <= 1'b0;
			end else if (state_q == cca_pkg::S_RETRY) begin
				pass2_q <= 1'b1;
			end
			out_valid_q <= cmd.out_load || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/circuit_channel_allocator.sv
// Circuit allocator top level. Release, add, set lock and a plain remove are applied
// in the decode state; a remove of the highest circuit adds top-code recovery. A reserve
// runs the bit-serial start remainder (increasing and random orders only) and then the
// one-circuit-per-cycle scan. One request at a time; the next one is taken while the
// previous response waits. Asynchronous active-low reset empties the group, reseeds the LFSR.
module circuit_channel_allocator #(
	parameter int CIRCUITS  = cca_pkg::CIRCUITS_DEF,
	parameter int LOCK_BITS = cca_pkg::LOCK_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cca_req_if.sink   req,
	cca_rsp_if.source rsp,
	cca_cfg_if.sink   cfg
);

	cca_pkg::dp_cmd_t cmd;
	cca_pkg::dp_sts_t sts;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	cca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cca_datapath #(
		.CIRCUITS  (CIRCUITS),
		.LOCK_BITS (LOCK_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.action          (req.action),
		.circuit_code    (req.circuit_code),
		.lock_check_mask (req.lock_check_mask),
		.lock_value      (req.lock_value),
		.swap_parity     (req.swap_parity),
		.cfg_we          (cfg.valid),
		.cfg_addr        (cfg.addr),
		.cfg_data        (cfg.data),
		.granted_code    (rsp.granted_code),
		.result_status   (rsp.result_status)
	);

endmodule

// File: tb/sv/circuit_grant_checker.sv
// Response checker for the circuit channel allocator testbench.
// Tracks group state from accepted requests and configuration writes, and compares each reply.
// Depends on cca_pkg and the channel interfaces in cca_if.sv.
`timescale 1ns / 100ps

module circuit_grant_checker #(
	parameter int CIRC = cca_pkg::CIRCUITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cca_req_if          req,
	cca_rsp_if          rsp,
	cca_cfg_if          cfg,
	output int unsigned mismatch_count,
	output int unsigned replies_owed
);

	// Random start generator, mirrored here.
	localparam logic [15:0] SHIFT_SEED = 16'hACE1;
	localparam logic [15:0] SHIFT_TAPS = 16'hB400;

	typedef struct packed {
		logic [cca_pkg::CODE_W-1:0]   code;
		logic [cca_pkg::STATUS_W-1:0] status;
	} reply_t;

	// Mirrored register settings.
	logic [cca_pkg::ORDER_W-1:0]  order_r;
	logic [cca_pkg::PARITY_W-1:0] parity_r;
	logic                         fallback_r;
	logic [cca_pkg::CODE_W-1:0]   base_r;

	// Mirrored group state.
	logic                       present[CIRC];
	logic                       busy[CIRC];
	logic [cca_pkg::MASK_W-1:0] locks[CIRC];
	int                         last_grant;
	int                         top_cnt;
	logic [15:0]                shift_reg;

	reply_t expected_replies[$];
	reply_t want;
	int unsigned reply_idx;

	function automatic logic parity_fits(int n, logic [cca_pkg::PARITY_W-1:0] par);
		if (par == cca_pkg::PAR_EVEN) return n[0] == 1'b0;
		if (par == cca_pkg::PAR_ODD) return n[0] == 1'b1;
		return 1'b1;
	endfunction

	function automatic logic can_take(int n, logic [cca_pkg::PARITY_W-1:0] par,
			logic [cca_pkg::MASK_W-1:0] mask);
		if (n >= CIRC || n >= top_cnt) return 1'b0;
		if (!present[n] || busy[n]) return 1'b0;
		if ((locks[n] & mask) != '0) return 1'b0;
		return parity_fits(n, par);
	endfunction

	// Next candidate in scan order, wrapping within the occupied code range.
	function automatic int step_code(int n, logic [cca_pkg::ORDER_W-1:0] ord,
			logic [cca_pkg::PARITY_W-1:0] par);
		int stride;
		stride = (par != cca_pkg::PAR_ANY) ? 2 : 1;
		if (ord == cca_pkg::ORD_INC || ord == cca_pkg::ORD_LOW) begin
			n += stride;
			if (n >= top_cnt) n = (par == cca_pkg::PAR_ODD) ? 1 : 0;
		end else if (ord == cca_pkg::ORD_DEC || ord == cca_pkg::ORD_HIGH) begin
			if (n >= stride) begin
				n -= stride;
			end else begin
				n = top_cnt - 1;
				if (!parity_fits(n, par) && n >= 1) n -= 1;
			end
		end else begin
			n = (n + 1) % top_cnt;
		end
		return n;
	endfunction

	// One pass over the group; returns the chosen local code or -1.
	function automatic int find_free(logic [cca_pkg::ORDER_W-1:0] ord,
			logic [cca_pkg::PARITY_W-1:0] par, logic [cca_pkg::MASK_W-1:0] mask);
		int n;
		int origin;
		int tries;
		case (ord)
			cca_pkg::ORD_INC:  n = (last_grant + 1) % top_cnt;
			cca_pkg::ORD_DEC:  n = ((last_grant != 0) ? last_grant : top_cnt) - 1;
			cca_pkg::ORD_LOW:  n = 0;
			cca_pkg::ORD_HIGH: n = top_cnt - 1;
			default: begin
				shift_reg = {1'b0, shift_reg[15:1]} ^ (shift_reg[0] ? SHIFT_TAPS : 16'h0000);
				n = int'(shift_reg) % top_cnt;
				// Avoid handing out the last grant again when there is a choice.
				if (top_cnt > 1 && n == last_grant) n = (n + 1) % top_cnt;
			end
		endcase
		if (par == cca_pkg::PAR_EVEN) n = n & ~1;
		else if (par == cca_pkg::PAR_ODD) n = n | 1;
		origin = n;
		tries = (par != cca_pkg::PAR_ANY) ? (top_cnt + 1) / 2 : top_cnt;
		while (tries > 0) begin
			tries--;
			if (can_take(n, par, mask)) return n;
			n = step_code(n, ord, par);
			if (n == origin) break;
		end
		return -1;
	endfunction

	// Applies one request to the mirrored state and returns the reply it should produce.
	function automatic reply_t predict_reply(logic [cca_pkg::ACTION_W-1:0] act,
			logic [cca_pkg::CODE_W-1:0] code, logic [cca_pkg::MASK_W-1:0] mask,
			logic [cca_pkg::MASK_W-1:0] lock_val, logic swap);
		reply_t r;
		int slot;
		int got;
		logic in_range;
		logic here;
		logic [cca_pkg::PARITY_W-1:0] par;
		r.code = '0;
		r.status = cca_pkg::ST_BAD_CODE;
		slot = 0;
		in_range = 1'b0;
		if (code >= base_r) begin
			slot = int'(code - base_r);
			in_range = slot < CIRC;
		end
		if (act == cca_pkg::ACT_RESERVE) begin
			if (top_cnt == 0) begin
				r.status = cca_pkg::ST_EMPTY;
			end else begin
				par = (parity_r == cca_pkg::PAR_ANY_ALT) ? cca_pkg::PAR_ANY : parity_r;
				if (swap && par != cca_pkg::PAR_ANY)
					par = (par == cca_pkg::PAR_EVEN) ? cca_pkg::PAR_ODD : cca_pkg::PAR_EVEN;
				got = find_free(order_r, par, mask);
				if (got < 0 && fallback_r && par != cca_pkg::PAR_ANY)
					got = find_free(order_r,
						(par == cca_pkg::PAR_EVEN) ? cca_pkg::PAR_ODD : cca_pkg::PAR_EVEN, mask);
				if (got >= 0) begin
					busy[got] = 1'b1;
					last_grant = got;
					r.code = cca_pkg::CODE_W'(got) + base_r;
					r.status = cca_pkg::ST_DONE;
				end else begin
					r.status = cca_pkg::ST_NONE_FREE;
				end
			end
		end else if (act <= cca_pkg::ACT_SETLOCK && in_range) begin
			here = present[slot];
			if (act == cca_pkg::ACT_RELEASE && here) begin
				busy[slot] = 1'b0;
				r.status = cca_pkg::ST_DONE;
			end else if (act == cca_pkg::ACT_ADD && !here) begin
				present[slot] = 1'b1;
				busy[slot] = 1'b0;
				locks[slot] = '0;
				if (top_cnt <= slot) top_cnt = slot + 1;
				r.status = cca_pkg::ST_DONE;
			end else if (act == cca_pkg::ACT_REMOVE && here) begin
				present[slot] = 1'b0;
				busy[slot] = 1'b0;
				locks[slot] = '0;
				top_cnt = 0;
				for (int k = 0; k < CIRC; k++)
					if (present[k]) top_cnt = k + 1;
				r.status = cca_pkg::ST_DONE;
			end else if (act == cca_pkg::ACT_SETLOCK && here) begin
				// All eight lock bits are kept at the default lock width.
				locks[slot] = lock_val;
				r.status = cca_pkg::ST_DONE;
			end
		end
		return r;
	endfunction

	function automatic void log_failure(string what);
		mismatch_count++;
		if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
	endfunction

	// Watch all three channels; requests are predicted before replies are retired.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_r = cca_pkg::ORD_INC;
			parity_r = cca_pkg::PAR_ANY;
			fallback_r = 1'b0;
			base_r = '0;
			for (int k = 0; k < CIRC; k++) begin
				present[k] = 1'b0;
				busy[k] = 1'b0;
				locks[k] = '0;
			end
			last_grant = 0;
			top_cnt = 0;
			shift_reg = SHIFT_SEED;
			expected_replies.delete();
			reply_idx = 0;
			replies_owed = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					cca_pkg::CFG_ORDER:    order_r = cfg.data[cca_pkg::ORDER_W-1:0];
					cca_pkg::CFG_PARITY:   parity_r = cfg.data[cca_pkg::PARITY_W-1:0];
					cca_pkg::CFG_FALLBACK: fallback_r = cfg.data[0];
					cca_pkg::CFG_BASE:     base_r = cfg.data[cca_pkg::CODE_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				expected_replies.push_back(predict_reply(req.action, req.circuit_code,
					req.lock_check_mask, req.lock_value, req.swap_parity));
			if (rsp.valid && rsp.ready) begin
				if (expected_replies.size() == 0) begin
					log_failure($sformatf("reply %0d with no request owed: code %h status %0d",
						reply_idx, rsp.granted_code, rsp.result_status));
				end else begin
					want = expected_replies.pop_front();
					if (want.code !== rsp.granted_code || want.status !== rsp.result_status)
						log_failure($sformatf(
							"reply %0d: expected code %h status %0d, got code %h status %0d",
							reply_idx, want.code, want.status, rsp.granted_code,
							rsp.result_status));
				end
				reply_idx++;
			end
			replies_owed = expected_replies.size();
		end
	end

endmodule

// File: tb/sv/testbench.sv
// Top of the circuit channel allocator testbench: clock, reset, request and register traffic.
// Instantiates the allocator and circuit_grant_checker; depends on cca_pkg and cca_if.sv.
`timescale 1ns / 100ps

module testbench;

	localparam int CIRC        = cca_pkg::CIRCUITS_DEF;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 250;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic quiet = 1'b0;

	int unsigned mismatch_count;
	int unsigned replies_owed;
	int unsigned request_total = 0;
	int unsigned reserve_total = 0;
	int unsigned write_total = 0;

	cca_req_if req_ch();
	cca_rsp_if rsp_ch();
	cca_cfg_if cfg_ch();

	circuit_channel_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	circuit_grant_checker #(.CIRC(CIRC)) grant_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.cfg            (cfg_ch),
		.mismatch_count (mismatch_count),
		.replies_owed   (replies_owed)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold a request until it is taken, then sometimes leave a gap before the next one.
	task automatic send_request(logic [cca_pkg::ACTION_W-1:0] act,
			logic [cca_pkg::CODE_W-1:0] code, logic [cca_pkg::MASK_W-1:0] mask,
			logic [cca_pkg::MASK_W-1:0] lock_val, logic swap);
		req_ch.action <= act;
		req_ch.circuit_code <= code;
		req_ch.lock_check_mask <= mask;
		req_ch.lock_value <= lock_val;
		req_ch.swap_parity <= swap;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		request_total++;
		if (act == cca_pkg::ACT_RESERVE) reserve_total++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Stop offering requests and wait until every reply has been taken.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (replies_owed != 0);
		@(posedge clk);
	endtask

	task automatic write_register(logic [cca_pkg::CFG_ADDR_W-1:0] addr,
			logic [cca_pkg::CFG_DATA_W-1:0] data);
		wait_drained();
		cfg_ch.addr <= addr;
		cfg_ch.data <= data;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		write_total++;
	endtask

	// Reply side: ready in random bursts with random stalls, steady in the quiet part.
	initial begin : reply_side
		int hold;
		logic level;
		rsp_ch.ready <= 1'b0;
		hold = 0;
		level = 1'b1;
		forever begin
			@(posedge clk);
			if (quiet) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				if (hold == 0) begin
					level = 1'($urandom_range(0, 1));
					hold = level ? $urandom_range(1, 40) : $urandom_range(1, 12);
				end
				hold--;
				rsp_ch.ready <= level;
			end
		end
	end

	// End the run if no channel makes progress for too long.
	initial begin : watchdog
		int idle_run;
		idle_run = 0;
		@(posedge arst_n);
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("No channel progress for %0d cycles", STALL_LIMIT);
		$display("[circuit_channel_allocator] ERROR");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int roll;
		logic [cca_pkg::ORDER_W-1:0]  ord;
		logic [cca_pkg::PARITY_W-1:0] par;
		logic                         fb;
		logic [cca_pkg::CODE_W-1:0]   base;
		logic [cca_pkg::ACTION_W-1:0] act;
		logic [cca_pkg::CODE_W-1:0]   code;
		logic [cca_pkg::MASK_W-1:0]   mask;

		req_ch.valid <= 1'b0;
		req_ch.action <= cca_pkg::ACT_RESERVE;
		req_ch.circuit_code <= '0;
		req_ch.lock_check_mask <= '0;
		req_ch.lock_value <= '0;
		req_ch.swap_parity <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.addr <= cca_pkg::CFG_ORDER;
		cfg_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings: base 0, increasing order, no parity limit.
		send_request(cca_pkg::ACT_RESERVE, 16'h0000, 8'h00, 8'h00, 1'b0);  // empty group
		send_request(cca_pkg::ACT_RELEASE, 16'h0000, 8'h00, 8'h00, 1'b0);  // absent circuit
		send_request(cca_pkg::ACT_ADD, 16'h0000, 8'h00, 8'h00, 1'b0);
		send_request(cca_pkg::ACT_ADD, 16'h001F, 8'h00, 8'h00, 1'b0);
		send_request(cca_pkg::ACT_ADD, 16'h001F, 8'h00, 8'h00, 1'b0);      // already present
		send_request(cca_pkg::ACT_ADD, 16'h0020, 8'h00, 8'h00, 1'b0);      // beyond the group
		send_request(cca_pkg::ACT_ADD, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
		send_request(cca_pkg::ACT_SETLOCK, 16'h001F, 8'h00, 8'hFF, 1'b0);
		send_request(cca_pkg::ACT_RESERVE, 16'h0000, 8'h01, 8'h00, 1'b0);  // scan wraps to 0
		send_request(cca_pkg::ACT_RESERVE, 16'h0000, 8'h80, 8'h00, 1'b0);  // nothing free
		send_request(cca_pkg::ACT_RESERVE, 16'hFFFF, 8'h00, 8'h00, 1'b0);  // locked one is fine
		send_request(cca_pkg::ACT_RELEASE, 16'h001F, 8'h00, 8'h00, 1'b0);
		send_request(cca_pkg::ACT_RELEASE, 16'h001F, 8'h00, 8'h00, 1'b0);  // already free
		send_request(cca_pkg::ACT_SETLOCK, 16'h0005, 8'h00, 8'h55, 1'b0);  // absent circuit
		send_request(cca_pkg::ACT_SETLOCK + 3'd1, 16'h0000, 8'h00, 8'h00, 1'b0);
		send_request(cca_pkg::ACT_SETLOCK + 3'd3, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
		send_request(cca_pkg::ACT_REMOVE, 16'h001F, 8'h00, 8'h00, 1'b0);   // top code falls back
		send_request(cca_pkg::ACT_REMOVE, 16'h001F, 8'h00, 8'h00, 1'b0);
		send_request(cca_pkg::ACT_RELEASE, 16'h0000, 8'h00, 8'h00, 1'b0);
		send_request(cca_pkg::ACT_ADD, 16'h0001, 8'h00, 8'h00, 1'b0);
		send_request(cca_pkg::ACT_RESERVE, 16'h0000, 8'h00, 8'h00, 1'b1);  // swap, no limit
		send_request(cca_pkg::ACT_RESERVE, 16'h0000, 8'h00, 8'h00, 1'b0);
		send_request(cca_pkg::ACT_REMOVE, 16'h0000, 8'h00, 8'h00, 1'b0);
		send_request(cca_pkg::ACT_REMOVE, 16'h0001, 8'h00, 8'h00, 1'b0);
		send_request(cca_pkg::ACT_RESERVE, 16'h0000, 8'h00, 8'h00, 1'b0);  // empty again

		// Random part: one register setting per phase, extremes first.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					ord = cca_pkg::ORD_INC; par = cca_pkg::PAR_ANY;
					fb = 1'b0; base = 16'h0000;
				end
				1: begin
					ord = cca_pkg::ORD_DEC; par = cca_pkg::PAR_EVEN;
					fb = 1'b1; base = 16'hFFFF;
				end
				2: begin
					ord = cca_pkg::ORD_LOW; par = cca_pkg::PAR_ODD;
					fb = 1'b0; base = 16'd100;
				end
				3: begin
					ord = cca_pkg::ORD_HIGH; par = cca_pkg::PAR_ANY_ALT;
					fb = 1'b1; base = 16'h0000;
				end
				4: begin
					ord = cca_pkg::ORD_HIGH + 3'd1; par = cca_pkg::PAR_EVEN;
					fb = 1'b0; base = cca_pkg::CODE_W'($urandom);
				end
				5: begin
					ord = '1; par = cca_pkg::PAR_ODD;
					fb = 1'b1; base = 16'hFFF0;
				end
				default: begin
					ord = cca_pkg::ORDER_W'($urandom_range(0, 7));
					par = cca_pkg::PARITY_W'($urandom_range(0, 3));
					fb = 1'($urandom_range(0, 1));
					base = $urandom_range(0, 1) ? 16'h0000 : cca_pkg::CODE_W'($urandom);
				end
			endcase
			write_register(cca_pkg::CFG_ORDER,
				{(cca_pkg::CFG_DATA_W - cca_pkg::ORDER_W)'($urandom), ord});
			write_register(cca_pkg::CFG_PARITY,
				{(cca_pkg::CFG_DATA_W - cca_pkg::PARITY_W)'($urandom), par});
			write_register(cca_pkg::CFG_FALLBACK, {(cca_pkg::CFG_DATA_W - 1)'($urandom), fb});
			write_register(cca_pkg::CFG_BASE, base);
			quiet = (phase == PHASES - 1);

			repeat (PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				if (roll < 32) act = cca_pkg::ACT_RESERVE;
				else if (roll < 55) act = cca_pkg::ACT_RELEASE;
				else if (roll < 75) act = cca_pkg::ACT_ADD;
				else if (roll < 85) act = cca_pkg::ACT_REMOVE;
				else if (roll < 97) act = cca_pkg::ACT_SETLOCK;
				else act = cca_pkg::ACT_SETLOCK + cca_pkg::ACTION_W'($urandom_range(1, 3));

				// Mostly codes inside the group, some arbitrary, some just outside it.
				roll = $urandom_range(0, 99);
				if (roll < 85) code = base + cca_pkg::CODE_W'($urandom_range(0, CIRC - 1));
				else if (roll < 95) code = cca_pkg::CODE_W'($urandom);
				else if (roll < 98) code = base - 16'd1;
				else code = base + cca_pkg::CODE_W'(CIRC);

				mask = ($urandom_range(0, 9) < 6) ? 8'h00 : cca_pkg::MASK_W'($urandom);
				send_request(act, code, mask, cca_pkg::MASK_W'($urandom),
					1'($urandom_range(0, 1)));
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (replies_owed != 0) $display("%0d replies never arrived", replies_owed);
		$display("Covered %0d requests (%0d reserves) over %0d register settings, %0d writes.",
			request_total, reserve_total, PHASES, write_total);
		if (mismatch_count == 0 && replies_owed == 0)
			$display("[circuit_channel_allocator] OK");
		else
			$display("[circuit_channel_allocator] ERROR");
		$finish;
	end

endmodule
